/* sv/platform_interrupt_controller_macros.svh */
// Assertion macros for the interrupt controller.
`ifndef PLATFORM_INTERRUPT_CONTROLLER_MACROS_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_MACROS_SVH

// The condition implies the property in the same cycle.
`define PIC_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// The condition implies the property in the next cycle.
`define PIC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* sv/pic_pkg.sv */
package pic_pkg;

  // Fixed configuration of the controller.
  localparam int NUM_SOURCES  = 32;
  localparam int NUM_CONTEXTS = 2;
  localparam int SRC_W        = 5;
  localparam int CTX_W        = 1;
  localparam logic [SRC_W-1:0] LAST_SRC = SRC_W'(NUM_SOURCES - 1);

  // Register map, byte offsets.
  localparam logic [25:0] PRIO_END    = 26'(4 * NUM_SOURCES);
  localparam logic [25:0] PEND_BASE   = 26'h1000;
  localparam logic [25:0] ENAB_BASE   = 26'h2000;
  localparam logic [25:0] ENAB_STRIDE = 26'h80;
  localparam logic [25:0] CTX_BASE    = 26'h200000;
  localparam logic [11:0] THR_OFS     = 12'h000;
  localparam logic [11:0] CLAIM_OFS   = 12'h004;

  // Actions of an input beat.
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RAISE = 2'd2;
  localparam logic [1:0] ACT_EVAL  = 2'd3;

  // Decoded commands.
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_RD_PRIO  = 4'd1;
  localparam logic [3:0] OP_WR_PRIO  = 4'd2;
  localparam logic [3:0] OP_RD_PEND  = 4'd3;
  localparam logic [3:0] OP_RD_ENAB  = 4'd4;
  localparam logic [3:0] OP_WR_ENAB  = 4'd5;
  localparam logic [3:0] OP_RD_THR   = 4'd6;
  localparam logic [3:0] OP_WR_THR   = 4'd7;
  localparam logic [3:0] OP_RD_CLAIM = 4'd8;
  localparam logic [3:0] OP_COMPLETE = 4'd9;
  localparam logic [3:0] OP_RAISE    = 4'd10;
  localparam logic [3:0] OP_EVAL     = 4'd11;

  typedef struct packed {
    logic [1:0]  action;
    logic [25:0] offset;
    logic [31:0] write_data;
    logic [4:0]  source;
    logic        context_req;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        raise_status;
    logic        irq_request;
  } out_item_t;

  typedef struct packed {
    logic [3:0]       op;
    logic [SRC_W-1:0] idx;
    logic [CTX_W-1:0] ctx;
    logic [31:0]      data;
  } cmd_t;

endpackage

/* sv/platform_interrupt_controller.sv */
// Interrupt controller with 32 sources and 2 target contexts, driven through a
// queue-style beat interface. A front stage decodes each input beat and places
// it in a two-entry command queue; the back stage executes it and posts one
// result beat in an output register. An evaluation scans the sources one per
// cycle through the single priority read port, and the back stage takes no new
// command until the scan ends. Input beats keep being accepted while the queue
// has room, even while a result waits to be popped.
`include "platform_interrupt_controller_macros.svh"

module platform_interrupt_controller import pic_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  request,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  pic_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  pic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // The back stage never takes from an empty queue.
  `PIC_ASSERT_NOW(a_take_valid, cmd_take, cmd_valid, "command taken from empty queue")
  // An evaluation holds back its result until the scan ends.
  `PIC_ASSERT_NEXT(a_eval_no_res, cmd_take && cmd.op == OP_EVAL, empty,
                   "result posted right after evaluation start")
  // Every other command posts its result in the next cycle.
  `PIC_ASSERT_NEXT(a_cmd_res, cmd_take && cmd.op != OP_EVAL, !empty,
                   "single-cycle command posted no result")

endmodule

/* sv/pic_front.sv */
module pic_front import pic_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t request,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output cmd_t     cmd
);

  logic [25:0] addr;
  logic        is_wr;
  cmd_t        dec;
  cmd_t        q [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        do_push;

  // Classify the incoming beat against the register map.
  always_comb begin
    addr     = {request.offset[25:2], 2'b00};
    is_wr    = (request.action == ACT_WRITE);
    dec.op   = OP_NONE;
    dec.idx  = addr[6:2];
    dec.ctx  = '0;
    dec.data = request.write_data;
    case (request.action)
      ACT_READ, ACT_WRITE: begin
        if (addr < PRIO_END) begin
          if (!is_wr) begin
            dec.op = OP_RD_PRIO;
          end else if (addr[6:2] != '0) begin
            dec.op = OP_WR_PRIO;
          end
        end else if (addr == PEND_BASE) begin
          if (!is_wr) begin
            dec.op = OP_RD_PEND;
          end
        end else if (addr == ENAB_BASE || addr == ENAB_BASE + ENAB_STRIDE) begin
          dec.ctx = addr[7];
          dec.op  = is_wr ? OP_WR_ENAB : OP_RD_ENAB;
        end else if (addr[25:13] == CTX_BASE[25:13]) begin
          dec.ctx = addr[12];
          if (addr[11:0] == THR_OFS) begin
            dec.op = is_wr ? OP_WR_THR : OP_RD_THR;
          end else if (addr[11:0] == CLAIM_OFS) begin
            dec.op = is_wr ? OP_COMPLETE : OP_RD_CLAIM;
          end
        end
      end
      ACT_RAISE: begin
        dec.op  = OP_RAISE;
        dec.idx = request.source;
      end
      ACT_EVAL: begin
        dec.op  = OP_EVAL;
        dec.ctx = request.context_req;
      end
      default: begin
        dec.op = OP_NONE;
      end
    endcase
  end

  // Two-entry command queue toward the execution side.
  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rptr];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (cmd_take) begin
        rptr <= !rptr;
      end
      count <= count + 2'(do_push) - 2'(cmd_take);
    end
  end

endmodule

/* sv/pic_back.sv */
module pic_back import pic_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_take,
  input  cmd_t      cmd,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                   st;
  logic [31:0]            prio [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] pending;
  logic [NUM_SOURCES-1:0] enable [NUM_CONTEXTS];
  logic [NUM_SOURCES-1:0] insvc [NUM_CONTEXTS];
  logic [31:0]            thr [NUM_CONTEXTS];
  logic [SRC_W-1:0]       sel [NUM_CONTEXTS];
  logic [SRC_W-1:0]       scan_idx;
  logic [CTX_W-1:0]       scan_ctx;
  logic [SRC_W-1:0]       best;
  logic [31:0]            high;
  logic                   res_valid;
  out_item_t              res;

  logic [SRC_W-1:0]       rd_idx;
  logic [31:0]            p;
  logic                   scan_clear;
  logic                   scan_hit;
  logic [SRC_W-1:0]       best_next;
  logic [SRC_W-1:0]       claim_src;
  logic                   raise_rej;
  out_item_t              exec_res;
  logic                   res_post;

  assign empty    = !res_valid;
  assign result   = res;
  assign cmd_take = (st == ST_IDLE) && cmd_valid && (!res_valid || pop);

  // A result is posted by any command other than an evaluation or by the last scan step.
  assign res_post = (st == ST_IDLE) ? (cmd_take && cmd.op != OP_EVAL)
                                    : (scan_idx == LAST_SRC);

  // One priority read a cycle: the scan step or the command's source.
  assign rd_idx = (st == ST_SCAN) ? scan_idx : cmd.idx;
  assign p      = prio[rd_idx];

  // One source of the evaluation scan.
  always_comb begin
    scan_clear = insvc[scan_ctx][scan_idx];
    scan_hit   = !scan_clear && enable[scan_ctx][scan_idx] && pending[scan_idx] &&
                 (p >= high) && (p >= thr[scan_ctx]);
    best_next  = scan_hit ? scan_idx : best;
  end

  // Result of a command other than an evaluation.
  always_comb begin
    claim_src = sel[cmd.ctx];
    raise_rej = (cmd.idx == '0) || pending[cmd.idx] || insvc[0][cmd.idx] ||
                insvc[NUM_CONTEXTS-1][cmd.idx];
    exec_res  = '0;
    case (cmd.op)
      OP_RD_PRIO:  exec_res.read_data = p;
      OP_RD_PEND:  exec_res.read_data = pending;
      OP_RD_ENAB:  exec_res.read_data = enable[cmd.ctx];
      OP_RD_THR:   exec_res.read_data = thr[cmd.ctx];
      OP_RD_CLAIM: exec_res.read_data = {27'b0, claim_src};
      OP_RAISE:    exec_res.raise_status = raise_rej;
      default:     exec_res = '0;
    endcase
  end

  // Execution sequencer and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      res_valid <= 1'b0;
      pending   <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        prio[i] <= '0;
      end
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        enable[c] <= '0;
        insvc[c]  <= '0;
        thr[c]    <= '0;
        sel[c]    <= '0;
      end
    end else begin
      if (res_post) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (cmd_take) begin
            if (cmd.op == OP_EVAL) begin
              st       <= ST_SCAN;
              scan_idx <= '0;
              scan_ctx <= cmd.ctx;
              best     <= '0;
              high     <= '0;
            end else begin
              res       <= exec_res;
              case (cmd.op)
                OP_WR_PRIO: prio[cmd.idx] <= cmd.data;
                OP_WR_ENAB: enable[cmd.ctx] <= cmd.data & ~32'h1;
                OP_WR_THR:  thr[cmd.ctx] <= cmd.data;
                OP_RD_CLAIM: begin
                  if (pending[claim_src]) begin
                    insvc[cmd.ctx][claim_src] <= 1'b1;
                  end
                end
                OP_COMPLETE: begin
                  if (cmd.data[31:SRC_W] == '0) begin
                    insvc[cmd.ctx][cmd.data[SRC_W-1:0]] <= 1'b0;
                  end
                end
                OP_RAISE: begin
                  if (!raise_rej) begin
                    pending[cmd.idx] <= 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        ST_SCAN: begin
          if (scan_clear) begin
            pending[scan_idx] <= 1'b0;
          end
          if (scan_hit) begin
            high <= p;
          end
          best <= best_next;
          if (scan_idx == LAST_SRC) begin
            st            <= ST_IDLE;
            sel[scan_ctx] <= best_next;
            res           <= '{read_data: '0, raise_status: 1'b0,
                               irq_request: (best_next != '0)};
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
